[src/osat_pkg.sv]
`timescale 1ns / 1ps

package osat_pkg;

  localparam int NOW_BITS      = 63;
  localparam int DUE_BITS      = 64;
  localparam int DELAY_BITS    = 32;
  localparam int US_BITS       = 20;
  localparam int PROD_BITS     = DELAY_BITS + US_BITS;
  localparam int IN_TAG_BITS   = 16;
  localparam int SLOT_IDX_BITS = 3;

  localparam logic [US_BITS-1:0] US_PER_SECOND = 20'd1000000;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_SCHED = 1'b1;

  typedef struct packed {
    logic live;
    logic mode;
    logic claimed;
    logic hit;
  } ctl_t;

endpackage

[src/osat_cell.sv]
`timescale 1ns / 1ps

module osat_cell #(
  parameter int TAG_BITS = 16,
  parameter int IDX      = 0
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  osat_pkg::ctl_t                       ctl_i,
  input  logic [osat_pkg::NOW_BITS-1:0]        now_i,
  input  logic [osat_pkg::DUE_BITS-1:0]        due_i,
  input  logic [TAG_BITS-1:0]                  tag_i,
  input  logic [osat_pkg::SLOT_IDX_BITS-1:0]   hit_idx_i,
  input  logic [TAG_BITS-1:0]                  hit_tag_i,
  output osat_pkg::ctl_t                       ctl_o,
  output logic [osat_pkg::NOW_BITS-1:0]        now_o,
  output logic [osat_pkg::DUE_BITS-1:0]        due_o,
  output logic [TAG_BITS-1:0]                  tag_o,
  output logic [osat_pkg::SLOT_IDX_BITS-1:0]   hit_idx_o,
  output logic [TAG_BITS-1:0]                  hit_tag_o
);

  logic                                valid_q, valid_d;
  logic [osat_pkg::DUE_BITS-1:0]       slot_due_q;
  logic [TAG_BITS-1:0]                 slot_tag_q;
  logic                                take;
  logic                                fire;
  osat_pkg::ctl_t                      ctl_q, ctl_d;
  logic [osat_pkg::SLOT_IDX_BITS-1:0]  hit_idx_d;
  logic [TAG_BITS-1:0]                 hit_tag_d;

  always_comb begin
    take      = 1'b0;
    fire      = 1'b0;
    valid_d   = valid_q;
    ctl_d     = ctl_i;
    hit_idx_d = hit_idx_i;
    hit_tag_d = hit_tag_i;
    if (ctl_i.live && !ctl_i.claimed) begin
      if (ctl_i.mode == osat_pkg::MODE_SCHED) begin
        take = ~valid_q;
      end else begin
        fire = valid_q && ({1'b0, now_i} >= slot_due_q);
      end
    end
    if (take) begin
      valid_d       = 1'b1;
      ctl_d.claimed = 1'b1;
      ctl_d.hit     = 1'b1;
      hit_idx_d     = osat_pkg::SLOT_IDX_BITS'(IDX);
    end
    if (fire) begin
      valid_d       = 1'b0;
      ctl_d.claimed = 1'b1;
      ctl_d.hit     = 1'b1;
      hit_idx_d     = osat_pkg::SLOT_IDX_BITS'(IDX);
      hit_tag_d     = slot_tag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ctl_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ctl_q   <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      slot_due_q <= due_i;
      slot_tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    now_o     <= now_i;
    due_o     <= due_i;
    tag_o     <= tag_i;
    hit_idx_o <= hit_idx_d;
    hit_tag_o <= hit_tag_d;
  end

  assign ctl_o = ctl_q;

endmodule

[src/one_shot_alarm_slot_table_top.sv]
`timescale 1ns / 1ps
// Requests are taken one at a time: a new request is not taken until the last one's
// result strobe; a request walks the row of slot cells one cell per cycle after the
// multiply and add stages, and the result strobe comes from the last cell.
// The next request is taken in the cycle that carries the result strobe.
// Reset clears all slot valid bits; results are never held off by the receiver.
module one_shot_alarm_slot_table_top #(
  parameter int SLOTS    = 8,
  parameter int TAG_BITS = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  output logic                                      busy_o,
  input  logic                                      mode_i,
  input  logic [osat_pkg::NOW_BITS-1:0]             now_time_i,
  input  logic [osat_pkg::DELAY_BITS-1:0]           delay_seconds_i,
  input  logic [osat_pkg::IN_TAG_BITS-1:0]          payload_tag_i,
  output logic                                      result_valid_o,
  output logic                                      done_res_o,
  output logic [osat_pkg::SLOT_IDX_BITS-1:0]        slot_index_o,
  output logic [osat_pkg::IN_TAG_BITS-1:0]          fired_tag_o
);

  logic                                 accept;
  logic                                 busy_q, busy_d;
  logic                                 a_live_q, b_live_q;
  logic                                 a_mode_q, b_mode_q;
  logic                                 a_zero_q, b_zero_q;
  logic [osat_pkg::NOW_BITS-1:0]        a_now_q, b_now_q;
  logic [osat_pkg::PROD_BITS-1:0]       a_prod_q;
  logic [osat_pkg::DUE_BITS-1:0]        b_due_q;
  logic [TAG_BITS-1:0]                  a_tag_q, b_tag_q;

  osat_pkg::ctl_t                       chain_ctl     [SLOTS+1];
  logic [osat_pkg::NOW_BITS-1:0]        chain_now     [SLOTS+1];
  logic [osat_pkg::DUE_BITS-1:0]        chain_due     [SLOTS+1];
  logic [TAG_BITS-1:0]                  chain_tag     [SLOTS+1];
  logic [osat_pkg::SLOT_IDX_BITS-1:0]   chain_hit_idx [SLOTS+1];
  logic [TAG_BITS-1:0]                  chain_hit_tag [SLOTS+1];

  assign accept = start_i & ~busy_o;
  assign busy_o = busy_q & ~chain_ctl[SLOTS].live;

  always_comb begin
    busy_d = busy_q;
    if (chain_ctl[SLOTS].live) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      a_live_q <= 1'b0;
      b_live_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      a_live_q <= accept;
      b_live_q <= a_live_q;
    end
  end

  // multiply stage, then add stage
  always_ff @(posedge clk_i) begin
    a_mode_q <= mode_i;
    a_zero_q <= (delay_seconds_i == '0);
    a_now_q  <= now_time_i;
    a_prod_q <= osat_pkg::PROD_BITS'(delay_seconds_i) *
                osat_pkg::PROD_BITS'(osat_pkg::US_PER_SECOND);
    a_tag_q  <= TAG_BITS'(payload_tag_i);
    b_mode_q <= a_mode_q;
    b_zero_q <= a_zero_q;
    b_now_q  <= a_now_q;
    b_due_q  <= {1'b0, a_now_q} + osat_pkg::DUE_BITS'(a_prod_q);
    b_tag_q  <= a_tag_q;
  end

  always_comb begin
    chain_ctl[0].live    = b_live_q;
    chain_ctl[0].mode    = b_mode_q;
    chain_ctl[0].claimed = (b_mode_q == osat_pkg::MODE_SCHED) && b_zero_q;
    chain_ctl[0].hit     = 1'b0;
  end

  assign chain_now[0]     = b_now_q;
  assign chain_due[0]     = b_due_q;
  assign chain_tag[0]     = b_tag_q;
  assign chain_hit_idx[0] = '0;
  assign chain_hit_tag[0] = '0;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    osat_cell #(
      .TAG_BITS (TAG_BITS),
      .IDX      (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (chain_ctl[k]),
      .now_i     (chain_now[k]),
      .due_i     (chain_due[k]),
      .tag_i     (chain_tag[k]),
      .hit_idx_i (chain_hit_idx[k]),
      .hit_tag_i (chain_hit_tag[k]),
      .ctl_o     (chain_ctl[k+1]),
      .now_o     (chain_now[k+1]),
      .due_o     (chain_due[k+1]),
      .tag_o     (chain_tag[k+1]),
      .hit_idx_o (chain_hit_idx[k+1]),
      .hit_tag_o (chain_hit_tag[k+1])
    );
  end

  assign result_valid_o = chain_ctl[SLOTS].live;
  assign done_res_o     = chain_ctl[SLOTS].hit;
  assign slot_index_o   = chain_hit_idx[SLOTS];
  assign fired_tag_o    = osat_pkg::IN_TAG_BITS'(chain_hit_tag[SLOTS]);

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  import osat_pkg::*;

  localparam int N_SLOTS     = 8;
  localparam int N_TAG_BITS  = 16;
  localparam int LATENCY     = N_SLOTS + 2;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_REQS = 1450;

  typedef struct packed {
    logic                     done;
    logic [SLOT_IDX_BITS-1:0] slot;
    logic [IN_TAG_BITS-1:0]   tag;
  } alarm_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  logic                   mode_i = MODE_TICK;
  logic [NOW_BITS-1:0]    now_time_i = '0;
  logic [DELAY_BITS-1:0]  delay_seconds_i = '0;
  logic [IN_TAG_BITS-1:0] payload_tag_i = '0;
  logic                   result_valid_o;
  logic                   done_res_o;
  logic [SLOT_IDX_BITS-1:0] slot_index_o;
  logic [IN_TAG_BITS-1:0]   fired_tag_o;

  logic                   slot_armed [N_SLOTS];
  logic [DUE_BITS-1:0]    slot_due_us [N_SLOTS];
  logic [IN_TAG_BITS-1:0] slot_tag_q [N_SLOTS];

  alarm_result_t pending_alarm_results[$];

  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned req_count;
  int unsigned sched_ok_count;
  int unsigned refused_count;
  int unsigned fired_count;
  int unsigned empty_tick_count;
  logic [NOW_BITS-1:0] sim_now_us;

  one_shot_alarm_slot_table_top #(
    .SLOTS   (N_SLOTS),
    .TAG_BITS(N_TAG_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .now_time_i     (now_time_i),
    .delay_seconds_i(delay_seconds_i),
    .payload_tag_i  (payload_tag_i),
    .result_valid_o (result_valid_o),
    .done_res_o     (done_res_o),
    .slot_index_o   (slot_index_o),
    .fired_tag_o    (fired_tag_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic alarm_result_t predict_alarm_result(
    input logic                   mode,
    input logic [NOW_BITS-1:0]    now_us,
    input logic [DELAY_BITS-1:0]  delay_s,
    input logic [IN_TAG_BITS-1:0] tag
  );
    alarm_result_t res;
    logic [DUE_BITS-1:0] now_ext;
    res = '0;
    now_ext = {1'b0, now_us};
    if (mode == MODE_SCHED) begin
      if (delay_s == '0) return res;
      for (int i = 0; i < N_SLOTS; i++) begin
        if (!slot_armed[i]) begin
          slot_armed[i]  = 1'b1;
          slot_due_us[i] = now_ext + DUE_BITS'(delay_s) * DUE_BITS'(US_PER_SECOND);
          slot_tag_q[i]  = tag & IN_TAG_BITS'((64'd1 << N_TAG_BITS) - 1);
          res.done = 1'b1;
          res.slot = SLOT_IDX_BITS'(i);
          return res;
        end
      end
      return res;
    end
    for (int i = 0; i < N_SLOTS; i++) begin
      if (slot_armed[i] && now_ext >= slot_due_us[i]) begin
        slot_armed[i] = 1'b0;
        res.done = 1'b1;
        res.slot = SLOT_IDX_BITS'(i);
        res.tag  = slot_tag_q[i];
        return res;
      end
    end
    return res;
  endfunction

  // hold the request until the block takes it, then queue its result
  task automatic send_alarm_req(
    input logic                   mode,
    input logic [NOW_BITS-1:0]    now_us,
    input logic [DELAY_BITS-1:0]  delay_s,
    input logic [IN_TAG_BITS-1:0] tag
  );
    alarm_result_t res;
    start_i         <= 1'b1;
    mode_i          <= mode;
    now_time_i      <= now_us;
    delay_seconds_i <= delay_s;
    payload_tag_i   <= tag;
    do @(posedge clk_i); while (busy_o);
    res = predict_alarm_result(mode, now_us, delay_s, tag);
    pending_alarm_results.push_back(res);
    req_count++;
    if (mode == MODE_SCHED) begin
      if (res.done) sched_ok_count++;
      else refused_count++;
    end else begin
      if (res.done) fired_count++;
      else empty_tick_count++;
    end
  endtask

  task automatic idle_cycles(input int unsigned n);
    if (n == 0) return;
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    alarm_result_t exp_res;
    if (rst_ni && result_valid_o) begin
      if (pending_alarm_results.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        exp_res = pending_alarm_results.pop_front();
        if (done_res_o !== exp_res.done) begin
          $error("done_res: expected %0d, actual %0d", exp_res.done, done_res_o);
          fail_count++;
        end
        if (slot_index_o !== exp_res.slot) begin
          $error("slot_index: expected %0d, actual %0d", exp_res.slot, slot_index_o);
          fail_count++;
        end
        if (fired_tag_o !== exp_res.tag) begin
          $error("fired_tag: expected %h, actual %h", exp_res.tag, fired_tag_o);
          fail_count++;
        end
      end
    end
  end

  task automatic test_empty_and_refused;
    send_alarm_req(MODE_TICK, '0, '0, '0);
    send_alarm_req(MODE_TICK, '1, '1, '1);
    send_alarm_req(MODE_SCHED, '1, '0, '1);
    send_alarm_req(MODE_SCHED, '0, '0, 16'h0000);
  endtask

  task automatic test_fill_fire_drain;
    logic [NOW_BITS-1:0] base;
    base = 63'd5_000_000;
    send_alarm_req(MODE_SCHED, base, 32'd1, 16'hFFFF);
    send_alarm_req(MODE_SCHED, '0, '1, 16'h0000);
    for (int i = 2; i < N_SLOTS; i++)
      send_alarm_req(MODE_SCHED, base, 32'd2, 16'(16'h1111 * i));
    send_alarm_req(MODE_SCHED, base, 32'd1, 16'hA5A5);
    idle_cycles(3);
    send_alarm_req(MODE_TICK, base + 63'd999_999, '0, '0);
    send_alarm_req(MODE_TICK, base + 63'd1_000_000, '0, '0);
    send_alarm_req(MODE_TICK, base + 63'd1_000_000, '0, '0);
    send_alarm_req(MODE_SCHED, base, 32'd3, 16'h5A5A);
    for (int i = 0; i < N_SLOTS; i++)
      send_alarm_req(MODE_TICK, '1, '1, '1);
    send_alarm_req(MODE_TICK, '1, '0, '0);
  endtask

  task automatic test_random_traffic;
    int unsigned burst_left;
    int unsigned pick;
    logic [NOW_BITS-1:0]    now_us;
    logic [DELAY_BITS-1:0]  delay_s;
    logic [IN_TAG_BITS-1:0] tag;
    burst_left = 0;
    sim_now_us = 63'd10_000_000;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
      end
      burst_left--;
      pick    = $urandom_range(0, 99);
      tag     = 16'($urandom);
      delay_s = $urandom;
      if (pick < 45) begin
        sim_now_us += 63'($urandom_range(0, 200000));
        now_us = ($urandom_range(0, 99) < 4) ? {31'($urandom), $urandom} : sim_now_us;
        pick = $urandom_range(0, 99);
        if (pick < 5) delay_s = '0;
        else if (pick >= 12) delay_s = $urandom_range(1, 4);
        send_alarm_req(MODE_SCHED, now_us, delay_s, tag);
      end else begin
        sim_now_us += 63'($urandom_range(0, 1500000));
        now_us = ($urandom_range(0, 99) < 6) ? {31'($urandom), $urandom} : sim_now_us;
        send_alarm_req(MODE_TICK, now_us, delay_s, tag);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < N_SLOTS; i++) begin
      slot_armed[i]  = 1'b0;
      slot_due_us[i] = '0;
      slot_tag_q[i]  = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_refused();
    test_fill_fire_drain();
    test_random_traffic();
    start_i <= 1'b0;
    while (pending_alarm_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    $display("Ran %0d requests: %0d alarms stored, %0d schedules refused,",
             req_count, sched_ok_count, refused_count);
    $display("%0d alarms fired, %0d ticks with nothing due.", fired_count, empty_tick_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
